[sv/assert_macros.svh]
// Assertion helpers shared by the RTL. Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define FFRA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define FFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ffra_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator package
// Sizes, codes and the block table entry layout for the first fit allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

	localparam int MAX_NODES    = 64;
	localparam int IDX_W        = $clog2(MAX_NODES);
	localparam int CNT_W        = $clog2(MAX_NODES + 1);
	localparam int HEAP_BYTES   = 2097152;
	localparam int HEADER_BYTES = 32;
	localparam int SUM_W        = 24;

	typedef enum logic [2:0] {
		REQ_ALLOC   = 3'd0,
		REQ_RELEASE = 3'd1,
		REQ_LOCK    = 3'd2,
		REQ_UNLOCK  = 3'd3,
		REQ_CLEANUP = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_NEW       = 2'd0,
		ST_SHARED    = 2'd1,
		ST_FAIL      = 2'd2,
		ST_UNMATCHED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [20:0] offset;
		logic [21:0] bytes;
		logic [31:0] owner;
		logic [15:0] refc;
		logic        lock;
		logic [31:0] stamp;
	} entry_t;

endpackage

[sv/first_fit_refcount_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First fit reference counted heap allocator
// Keeps an address ordered block table in one RAM and serves alloc, release,
// lock, unlock and cleanup requests one at a time.
// ----------------------------------------------------------------------------
// Every request walks the live part of the block table through the single RAM
// read port, one entry per cycle; an alloc that lands in an inner gap then moves
// the entries above it up by one. A new request is taken while the previous
// result waits at the output.
`include "assert_macros.svh"

module first_fit_refcount_allocator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] owner_id,
	input  logic [21:0]        request_bytes,
	input  logic [21:0]        data_handle,
	input  logic signed [31:0] frame_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [21:0]        result_handle
);

	localparam int IW = ffra_pkg::IDX_W;
	localparam int CW = ffra_pkg::CNT_W;
	localparam int SW = ffra_pkg::SUM_W;

	ffra_pkg::state_t  state_q, state_d;
	logic [CW-1:0]     live_q, cnt_q, w_q;
	logic              pend_q;
	logic [IW-1:0]     idx_s1;
	logic [2:0]        req_q;
	logic [31:0]       owner_q, frame_q;
	logic [22:0]       need_q;
	logic [21:0]       handle_q;
	logic              match_q, gap_q;
	logic [IW-1:0]     midx_q, gidx_q;
	ffra_pkg::entry_t  mentry_q, prev_q;
	logic [20:0]       gap_off_q;
	ffra_pkg::status_t res_status_q;
	logic [21:0]       res_handle_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [21:0]       handle_out_q;

	ffra_pkg::entry_t  rd, wdata;
	logic              re, we, issue, done;
	logic [IW-1:0]     raddr, waddr;
	logic [CW-1:0]     cnt_m1;
	logic [22:0]       need_r;
	logic [SW-1:0]     gap_diff, gap_req, tail_end;
	logic [31:0]       age;
	logic [31:0]       stamp_n;
	logic              keep, owner_hit, gap_hit, handle_hit;
	logic              fin_load, live_load;
	logic [CW-1:0]     live_d;
	ffra_pkg::status_t fin_status;
	logic [21:0]       fin_handle;

	function automatic ffra_pkg::entry_t new_entry(logic [20:0] off, logic [22:0] need,
		logic [31:0] owner);
		ffra_pkg::entry_t e;
		e.offset = off;
		e.bytes  = need[21:0];
		e.owner  = owner;
		e.refc   = 16'd1;
		e.lock   = 1'b0;
		e.stamp  = '1;
		return e;
	endfunction

	ffra_ram #(.WIDTH($bits(ffra_pkg::entry_t)), .DEPTH(ffra_pkg::MAX_NODES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rd)
	);

	assign need_r   = {1'b0, request_bytes} + 23'd15;
	assign cnt_m1   = cnt_q - CW'(1);
	assign gap_diff = SW'(rd.offset) - SW'(prev_q.offset);
	assign gap_req  = SW'(prev_q.bytes) + SW'(need_q);
	assign tail_end = SW'(prev_q.offset) + SW'(prev_q.bytes) + SW'(need_q);
	assign age      = frame_q - rd.stamp;
	assign stamp_n  = age[27] ? rd.stamp : '1;
	assign keep     = !(rd.refc == 16'd0 && !rd.lock && stamp_n[31]);

	assign owner_hit  = req_q == ffra_pkg::REQ_ALLOC && owner_q != 32'd0 && !match_q &&
		rd.owner == owner_q;
	assign gap_hit    = req_q == ffra_pkg::REQ_ALLOC && idx_s1 != '0 && !gap_q &&
		gap_diff >= gap_req;
	assign handle_hit = (req_q == ffra_pkg::REQ_RELEASE || req_q == ffra_pkg::REQ_LOCK ||
		req_q == ffra_pkg::REQ_UNLOCK) && !match_q &&
		(23'(rd.offset) + 23'(ffra_pkg::HEADER_BYTES)) == {1'b0, handle_q};

	always_comb begin
		state_d    = state_q;
		re         = 1'b0;
		raddr      = cnt_q[IW-1:0];
		we         = 1'b0;
		waddr      = idx_s1;
		wdata      = rd;
		issue      = 1'b0;
		done       = 1'b0;
		fin_load   = 1'b0;
		fin_status = ffra_pkg::ST_NEW;
		fin_handle = '0;
		live_load  = 1'b0;
		live_d     = live_q;
		unique case (state_q)
			ffra_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = ffra_pkg::S_SCAN;
				end
			end
			ffra_pkg::S_SCAN: begin
				issue = cnt_q < live_q;
				re    = issue;
				done  = !issue && !pend_q;
				if (pend_q && req_q == ffra_pkg::REQ_CLEANUP && keep) begin
					we          = 1'b1;
					waddr       = w_q[IW-1:0];
					wdata       = rd;
					wdata.stamp = stamp_n;
				end
				if (done) begin
					fin_load = 1'b1;
					state_d  = ffra_pkg::S_FINISH;
					unique case (req_q) inside
						ffra_pkg::REQ_ALLOC: begin
							fin_status = ffra_pkg::ST_FAIL;
							if (match_q) begin
								we         = 1'b1;
								waddr      = midx_q;
								wdata      = mentry_q;
								wdata.refc = mentry_q.refc + 16'd1;
								if (23'(mentry_q.bytes) == need_q) begin
									fin_status = ffra_pkg::ST_SHARED;
									fin_handle = 22'(mentry_q.offset) +
										22'(ffra_pkg::HEADER_BYTES);
								end
							end else if (live_q == '0) begin
								if (SW'(need_q) <= SW'(ffra_pkg::HEAP_BYTES)) begin
									we         = 1'b1;
									waddr      = '0;
									wdata      = new_entry('0, need_q, owner_q);
									live_load  = 1'b1;
									live_d     = CW'(1);
									fin_status = ffra_pkg::ST_NEW;
									fin_handle = 22'(ffra_pkg::HEADER_BYTES);
								end
							end else if (live_q >= CW'(ffra_pkg::MAX_NODES)) begin
								fin_status = ffra_pkg::ST_FAIL;
							end else if (gap_q) begin
								fin_load = 1'b0;
								state_d  = ffra_pkg::S_SHIFT;
							end else if (tail_end <= SW'(ffra_pkg::HEAP_BYTES)) begin
								we         = 1'b1;
								waddr      = live_q[IW-1:0];
								wdata      = new_entry(21'(prev_q.offset + 21'(prev_q.bytes)),
									need_q, owner_q);
								live_load  = 1'b1;
								live_d     = live_q + CW'(1);
								fin_status = ffra_pkg::ST_NEW;
								fin_handle = 22'(wdata.offset) + 22'(ffra_pkg::HEADER_BYTES);
							end
						end
						ffra_pkg::REQ_RELEASE, ffra_pkg::REQ_LOCK,
						ffra_pkg::REQ_UNLOCK: begin
							if (match_q) begin
								we    = 1'b1;
								waddr = midx_q;
								wdata = mentry_q;
								if (req_q == ffra_pkg::REQ_RELEASE) begin
									wdata.refc  = mentry_q.refc - 16'd1;
									wdata.stamp = frame_q;
								end else begin
									wdata.lock = req_q == ffra_pkg::REQ_LOCK;
								end
								fin_status = ffra_pkg::ST_NEW;
							end else begin
								fin_status = ffra_pkg::ST_UNMATCHED;
							end
						end
						ffra_pkg::REQ_CLEANUP: begin
							live_load  = 1'b1;
							live_d     = w_q;
							fin_status = ffra_pkg::ST_NEW;
						end
						default: begin
							fin_status = ffra_pkg::ST_FAIL;
						end
					endcase
				end
			end
			ffra_pkg::S_SHIFT: begin
				issue = cnt_q > (CW'(gidx_q) + CW'(1));
				re    = issue;
				raddr = cnt_m1[IW-1:0];
				done  = !issue && !pend_q;
				if (pend_q) begin
					we    = 1'b1;
					waddr = idx_s1 + IW'(1);
					wdata = rd;
				end
				if (done) begin
					we         = 1'b1;
					waddr      = gidx_q + IW'(1);
					wdata      = new_entry(gap_off_q, need_q, owner_q);
					live_load  = 1'b1;
					live_d     = live_q + CW'(1);
					fin_load   = 1'b1;
					fin_status = ffra_pkg::ST_NEW;
					fin_handle = 22'(gap_off_q) + 22'(ffra_pkg::HEADER_BYTES);
					state_d    = ffra_pkg::S_FINISH;
				end
			end
			ffra_pkg::S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ffra_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ffra_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffra_pkg::S_IDLE;
			live_q      <= '0;
			cnt_q       <= '0;
			w_q         <= '0;
			pend_q      <= 1'b0;
			match_q     <= 1'b0;
			gap_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= issue;
			if (live_load) begin
				live_q <= live_d;
			end
			if (state_q == ffra_pkg::S_IDLE && in_valid) begin
				cnt_q   <= '0;
				w_q     <= '0;
				match_q <= 1'b0;
				gap_q   <= 1'b0;
			end else if (state_q == ffra_pkg::S_SCAN) begin
				if (issue) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (pend_q && (owner_hit || handle_hit)) begin
					match_q <= 1'b1;
				end
				if (pend_q && gap_hit) begin
					gap_q <= 1'b1;
				end
				if (pend_q && req_q == ffra_pkg::REQ_CLEANUP && keep) begin
					w_q <= w_q + CW'(1);
				end
				if (done) begin
					cnt_q <= live_q;
				end
			end else if (state_q == ffra_pkg::S_SHIFT && issue) begin
				cnt_q <= cnt_m1;
			end
			if (state_q == ffra_pkg::S_FINISH && state_d == ffra_pkg::S_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ffra_pkg::S_IDLE && in_valid) begin
			req_q    <= req_type;
			owner_q  <= owner_id;
			need_q   <= {need_r[22:4], 4'b0} + 23'(ffra_pkg::HEADER_BYTES);
			handle_q <= data_handle;
			frame_q  <= frame_value;
		end
		if (issue) begin
			idx_s1 <= raddr;
		end
		if (state_q == ffra_pkg::S_SCAN && pend_q) begin
			prev_q <= rd;
			if (owner_hit || handle_hit) begin
				midx_q   <= idx_s1;
				mentry_q <= rd;
			end
			if (gap_hit) begin
				gidx_q    <= idx_s1 - IW'(1);
				gap_off_q <= prev_q.offset + 21'(prev_q.bytes);
			end
		end
		if (fin_load) begin
			res_status_q <= fin_status;
			res_handle_q <= fin_handle;
		end
		if (state_q == ffra_pkg::S_FINISH && state_d == ffra_pkg::S_IDLE) begin
			status_q     <= res_status_q;
			handle_out_q <= res_handle_q;
		end
	end

	assign in_stall      = state_q != ffra_pkg::S_IDLE;
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign result_handle = handle_out_q;

	`FFRA_ASSERT(a_live_bound, live_q <= CW'(ffra_pkg::MAX_NODES), "live count beyond table")
	`FFRA_ASSERT(a_idle_no_read, state_q != ffra_pkg::S_IDLE || !pend_q, "read pending in idle")
	`FFRA_ASSERT(a_compact_order, !(state_q == ffra_pkg::S_SCAN && pend_q &&
		req_q == ffra_pkg::REQ_CLEANUP) || w_q <= CW'(idx_s1), "compaction overtakes read")
	`FFRA_ASSERT_NEXT(a_accept_scan, in_valid && !in_stall, state_q == ffra_pkg::S_SCAN,
		"accepted request did not start a scan")

endmodule

[sv/ffra_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ffra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[bench/tb_first_fit_refcount_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator testbench
// Drives alloc, release, lock, unlock and cleanup words into the first fit
// allocator, predicts every result with a behavioral copy of the block table
// and compares status and handle word by word, under several idling phases.
// ----------------------------------------------------------------------------
module tb_first_fit_refcount_allocator;

	typedef struct {
		logic [1:0]  st;
		logic [21:0] hnd;
	} outcome_t;

	class alloc_scoreboard;
		int unsigned n_live;
		longint unsigned offs[ffra_pkg::MAX_NODES];
		longint unsigned sizes[ffra_pkg::MAX_NODES];
		bit [31:0] owners[ffra_pkg::MAX_NODES];
		bit [15:0] counts[ffra_pkg::MAX_NODES];
		bit locks[ffra_pkg::MAX_NODES];
		bit [31:0] stamps[ffra_pkg::MAX_NODES];
		outcome_t pending[$];
		int errors;
		int n_checked;

		function void put(int i, longint unsigned off, longint unsigned need, bit [31:0] own);
			offs[i] = off;
			sizes[i] = need;
			owners[i] = own;
			counts[i] = 16'd1;
			locks[i] = 1'b0;
			stamps[i] = 32'hFFFF_FFFF;
		endfunction

		function void move(int dst, int src);
			offs[dst] = offs[src];
			sizes[dst] = sizes[src];
			owners[dst] = owners[src];
			counts[dst] = counts[src];
			locks[dst] = locks[src];
			stamps[dst] = stamps[src];
		endfunction

		function outcome_t place(bit [31:0] own, longint unsigned req);
			outcome_t o;
			longint unsigned need, off;
			int last;
			need = (((req + 15) >> 4) << 4) + ffra_pkg::HEADER_BYTES;
			o.st = ffra_pkg::ST_FAIL;
			o.hnd = '0;
			if (own != 0) begin
				for (int i = 0; i < n_live; i++) begin
					if (owners[i] == own) begin
						counts[i] = counts[i] + 16'd1;
						if (sizes[i] == need) begin
							o.st = ffra_pkg::ST_SHARED;
							o.hnd = 22'(offs[i] + ffra_pkg::HEADER_BYTES);
						end
						return o;
					end
				end
			end
			if (n_live == 0) begin
				if (need <= ffra_pkg::HEAP_BYTES) begin
					put(0, 0, need, own);
					n_live = 1;
					o.st = ffra_pkg::ST_NEW;
					o.hnd = 22'(ffra_pkg::HEADER_BYTES);
				end
				return o;
			end
			if (n_live >= ffra_pkg::MAX_NODES)
				return o;
			for (int i = 0; i + 1 < n_live; i++) begin
				if (offs[i + 1] - offs[i] >= sizes[i] + need) begin
					off = offs[i] + sizes[i];
					for (int j = n_live; j > i + 1; j--)
						move(j, j - 1);
					put(i + 1, off, need, own);
					n_live++;
					o.st = ffra_pkg::ST_NEW;
					o.hnd = 22'(off + ffra_pkg::HEADER_BYTES);
					return o;
				end
			end
			last = n_live - 1;
			if (ffra_pkg::HEAP_BYTES >= offs[last] + sizes[last] + need) begin
				off = offs[last] + sizes[last];
				put(n_live, off, need, own);
				n_live++;
				o.st = ffra_pkg::ST_NEW;
				o.hnd = 22'(off + ffra_pkg::HEADER_BYTES);
			end
			return o;
		endfunction

		function void sweep(bit [31:0] frame);
			int w;
			bit [31:0] age;
			w = 0;
			for (int i = 0; i < n_live; i++) begin
				age = (frame - stamps[i]) & 32'h0FFF_FFFF;
				if (age <= 32'h07FF_FFFF)
					stamps[i] = 32'hFFFF_FFFF;
				if (!(counts[i] == 0 && !locks[i] && stamps[i][31])) begin
					if (w != i)
						move(w, i);
					w++;
				end
			end
			n_live = w;
		endfunction

		function void note_request(logic [2:0] kind, logic [31:0] own, logic [21:0] req,
			logic [21:0] hnd, logic [31:0] frame);
			outcome_t o;
			int idx;
			o.st = ffra_pkg::ST_NEW;
			o.hnd = '0;
			case (kind) inside
				ffra_pkg::REQ_ALLOC: o = place(own, 64'(req));
				ffra_pkg::REQ_RELEASE, ffra_pkg::REQ_LOCK, ffra_pkg::REQ_UNLOCK: begin
					idx = -1;
					if (hnd != 0)
						for (int i = 0; i < n_live; i++)
							if (idx < 0 && offs[i] + ffra_pkg::HEADER_BYTES == 64'(hnd))
								idx = i;
					if (idx < 0)
						o.st = ffra_pkg::ST_UNMATCHED;
					else if (kind == ffra_pkg::REQ_RELEASE) begin
						counts[idx] = counts[idx] - 16'd1;
						stamps[idx] = frame;
					end else
						locks[idx] = (kind == ffra_pkg::REQ_LOCK);
				end
				ffra_pkg::REQ_CLEANUP: sweep(frame);
				default: o.st = ffra_pkg::ST_FAIL;
			endcase
			pending.push_back(o);
		endfunction

		function void check_result(logic [1:0] st, logic [21:0] hnd);
			outcome_t o;
			n_checked++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: status %0d handle %0h",
					$time, st, hnd);
				return;
			end
			o = pending.pop_front();
			if (st !== o.st) begin
				errors++;
				$display("%0t: status expected %0d actual %0d", $time, o.st, st);
			end
			if (hnd !== o.hnd) begin
				errors++;
				$display("%0t: handle expected %0h actual %0h", $time, o.hnd, hnd);
			end
		endfunction

		function longint unsigned live_handle();
			if (n_live == 0)
				return 0;
			return offs[$urandom_range(n_live - 1)] + ffra_pkg::HEADER_BYTES;
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [2:0] req_type;
	logic signed [31:0] owner_id, frame_value;
	logic [21:0] request_bytes, data_handle;
	logic [1:0] status;
	logic [21:0] result_handle;

	alloc_scoreboard board;
	int send_idle, recv_stall;
	int n_sent;

	first_fit_refcount_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .owner_id(owner_id), .request_bytes(request_bytes),
		.data_handle(data_handle), .frame_value(frame_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .result_handle(result_handle)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(status, result_handle);
		out_stall <= ($urandom_range(99) < recv_stall);
	end

	task automatic send(logic [2:0] kind, logic [31:0] own, logic [21:0] req,
		logic [21:0] hnd, logic [31:0] frame);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		req_type <= kind;
		owner_id <= own;
		request_bytes <= req;
		data_handle <= hnd;
		frame_value <= frame;
		do
			@(posedge clk);
		while (in_stall);
		board.note_request(kind, own, req, hnd, frame);
		n_sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic random_word();
		int pick;
		logic [31:0] own;
		logic [21:0] req, hnd;
		pick = $urandom_range(99);
		own = ($urandom_range(2) == 0) ? 32'd0 : 32'($urandom_range(7));
		if ($urandom_range(9) == 0)
			own = $urandom;
		req = ($urandom_range(19) == 0) ? 22'($urandom) : 22'($urandom_range(20000));
		hnd = ($urandom_range(7) == 0) ? 22'($urandom) : 22'(board.live_handle());
		if (pick < 40)
			send(ffra_pkg::REQ_ALLOC, own, req, 22'($urandom), $urandom);
		else if (pick < 65)
			send(ffra_pkg::REQ_RELEASE, $urandom, 22'($urandom), hnd,
				$urandom_range(3) == 0 ? $urandom : 32'(n_sent));
		else if (pick < 75)
			send(ffra_pkg::REQ_LOCK, $urandom, 22'($urandom), hnd, $urandom);
		else if (pick < 83)
			send(ffra_pkg::REQ_UNLOCK, $urandom, 22'($urandom), hnd, $urandom);
		else if (pick < 97)
			send(ffra_pkg::REQ_CLEANUP, $urandom, 22'($urandom), 22'($urandom),
				$urandom_range(1) ? 32'(n_sent + $urandom_range(3)) : $urandom);
		else
			send(3'($urandom_range(7, 5)), $urandom, 22'($urandom), 22'($urandom),
				$urandom);
	endtask

	initial begin
		board = new();
		send_idle = 0;
		recv_stall = 0;
		n_sent = 0;
		arst_n = 0;
		in_valid = 0;
		out_stall = 0;
		req_type = ffra_pkg::REQ_ALLOC;
		owner_id = 0;
		request_bytes = 0;
		data_handle = 0;
		frame_value = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(ffra_pkg::REQ_RELEASE, 0, 0, 0, 0);
		send(ffra_pkg::REQ_ALLOC, 0, 22'h3FFFFF, 0, 0);
		send(ffra_pkg::REQ_ALLOC, 5, 0, 0, 0);
		send(ffra_pkg::REQ_ALLOC, 5, 0, 0, 0);
		send(ffra_pkg::REQ_ALLOC, 5, 17, 0, 0);
		send(ffra_pkg::REQ_ALLOC, 32'h8000_0000, 1, 0, 0);
		send(ffra_pkg::REQ_ALLOC, 32'h7FFF_FFFF, 22'd2097152, 0, 0);
		send(ffra_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 100, 0, 0);
		send(ffra_pkg::REQ_LOCK, 0, 0, 32, 0);
		send(ffra_pkg::REQ_UNLOCK, 0, 0, 33, 0);
		send(ffra_pkg::REQ_RELEASE, 0, 0, 32, 32'h7FFF_FFFF);
		send(ffra_pkg::REQ_RELEASE, 0, 0, 32, 32'h8000_0000);
		send(ffra_pkg::REQ_RELEASE, 0, 0, 22'h3FFFFF, 0);
		send(ffra_pkg::REQ_CLEANUP, 0, 0, 0, 32'h8800_0000);
		send(ffra_pkg::REQ_CLEANUP, 0, 0, 0, 32'h8000_0000);
		send(ffra_pkg::REQ_UNLOCK, 0, 0, 32, 0);
		send(ffra_pkg::REQ_ALLOC, 0, 16, 0, 0);
		send(3'd7, 32'hFFFF_FFFF, 22'h3FFFFF, 22'h3FFFFF, 32'hFFFF_FFFF);
		for (int i = 0; i < 66; i++)
			send(ffra_pkg::REQ_ALLOC, 0, 0, 0, 0);
		send(ffra_pkg::REQ_ALLOC, 5, 0, 0, 0);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 59; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 59; end
				3: begin send_idle = 33; recv_stall = 33; end
				default: begin send_idle = 0; recv_stall = 0; end
			endcase
			for (int k = 0; k < 64; k++)
				random_word();
			drain();
		end

		$display("Sent %0d request words; checked %0d results over five idling phases.",
			n_sent, board.n_checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
